// ===== hw/rtl/cec_pkg.sv =====
package cec_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 32;
    localparam int NUM_SITES  = 3;

    // Determinant datapath
    localparam int DIFF_BITS = COORD_BITS + 1;             // site differences
    localparam int SQ_BITS   = 2 * DIFF_BITS + 1;          // lifted terms and DD
    localparam int DN_BITS   = SQ_BITS + DIFF_BITS + 1;    // DX, DY
    localparam int DEN_BITS  = SQ_BITS + 1;                // 2*|DD|
    localparam int QN_BITS   = DN_BITS + FRAC_BITS;        // scaled numerator / quotient
    localparam int QC_BITS   = (QN_BITS + 1 > 42) ? QN_BITS + 1 : 42;

    // Center assembly
    localparam int V_BITS    = 43;
    localparam int LIMIT_EXP = 40;

    // Distance datapath
    localparam int SX_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DX_BITS   = ((SX_BITS > OUT_BITS) ? SX_BITS : OUT_BITS) + 1;
    localparam int SS_BITS   = 2 * DX_BITS;
    localparam int ROOT_BITS = SS_BITS / 2;
    localparam int RR_BITS   = ROOT_BITS + 2;
    localparam int EV_BITS   = ((ROOT_BITS + 1 > OUT_BITS) ? ROOT_BITS + 1 : OUT_BITS) + 1;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [QC_BITS-1:0] CENTER_LIMIT = QC_BITS'(64'd1 << LIMIT_EXP);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_COLLINEAR = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
    } site_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] center_x;
        logic signed [OUT_BITS-1:0] center_y;
        logic signed [OUT_BITS-1:0] event_pos;
        status_t                    status;
    } circle_out_t;

    typedef struct packed {
        logic [QN_BITS-1:0]  nq;     // numerator bits shift out, quotient bits shift in
        logic [DEN_BITS-1:0] rem;
    } div_lane_t;

    typedef struct packed {
        div_lane_t           x;
        div_lane_t           y;
        logic [DEN_BITS-1:0] den;
    } div_work_t;

    typedef struct packed {
        site_in_t sites;
        logic     collinear;
        logic     neg_x;
        logic     neg_y;
    } side_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] cx;
        logic signed [OUT_BITS-1:0] cy;
        logic                       sat;
        logic                       collinear;
    } sq_side_t;

    typedef struct packed {
        logic [SS_BITS-1:0]   rad;
        logic [RR_BITS-1:0]   rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic                       sat;
        logic signed [OUT_BITS-1:0] val;
    } clamp_t;

    // One restoring division step
    function automatic div_lane_t div_step(input div_lane_t cur, input logic [DEN_BITS-1:0] den);
        logic [DEN_BITS:0] r;
        logic [DEN_BITS:0] diff;
        div_lane_t nxt;
        r    = {cur.rem, cur.nq[QN_BITS-1]};
        diff = r - {1'b0, den};
        if (r >= {1'b0, den})
        begin
            nxt.rem = diff[DEN_BITS-1:0];
            nxt.nq  = {cur.nq[QN_BITS-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = r[DEN_BITS-1:0];
            nxt.nq  = {cur.nq[QN_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // One digit-by-digit square root step (two radicand bits)
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t cur);
        logic [RR_BITS+1:0] t;
        logic [RR_BITS+1:0] trial;
        logic [RR_BITS+1:0] diff;
        sqrt_lane_t nxt;
        t     = {cur.rem, cur.rad[SS_BITS-1 -: 2]};
        trial = (RR_BITS+2)'({cur.root, 2'b01});
        diff  = t - trial;
        nxt.rad = cur.rad << 2;
        if (t >= trial)
        begin
            nxt.rem  = diff[RR_BITS-1:0];
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = t[RR_BITS-1:0];
            nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic clamp_t clamp_center(input logic signed [V_BITS-1:0] v,
                                            input logic over, input logic neg);
        clamp_t c;
        if (over)
        begin
            c.sat = 1'b1;
            c.val = neg ? OUT_MIN : OUT_MAX;
        end
        else if (v > V_BITS'(OUT_MAX))
        begin
            c.sat = 1'b1;
            c.val = OUT_MAX;
        end
        else if (v < V_BITS'(OUT_MIN))
        begin
            c.sat = 1'b1;
            c.val = OUT_MIN;
        end
        else
        begin
            c.sat = 1'b0;
            c.val = v[OUT_BITS-1:0];
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/cec_stream_if.sv =====
interface cec_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cec_front.sv =====
module cec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cec_pkg::site_in_t    in_payload,
    output logic                 out_valid,
    output cec_pkg::div_work_t   out_work,
    output cec_pkg::side_t       out_side
);
    localparam int STAGES = 6;
    localparam int DIFF   = cec_pkg::DIFF_BITS;
    localparam int SQ     = cec_pkg::SQ_BITS;
    localparam int DN     = cec_pkg::DN_BITS;

    typedef struct packed {
        logic signed [DIFF-1:0] ax;
        logic signed [DIFF-1:0] ay;
        logic signed [DIFF-1:0] bx;
        logic signed [DIFF-1:0] by;
    } diff_t;

    logic [STAGES-1:0]  valid_reg;
    cec_pkg::site_in_t  site_reg [STAGES-1];
    diff_t              diff_reg [3];
    diff_t              diff_next;

    logic signed [2*DIFF-1:0] sq_ax_reg, sq_ay_reg, sq_bx_reg, sq_by_reg;
    logic signed [2*DIFF-1:0] aby_reg, bxay_reg;
    logic signed [SQ-1:0]     sa_reg, sb_reg, dd3_reg, dd4_reg;
    logic signed [DN-2:0]     m1_reg, m2_reg, m3_reg, m4_reg;
    logic                     col4_reg, col5_reg;
    logic signed [DN-1:0]     dxn_reg, dyn_reg;
    logic [cec_pkg::DEN_BITS-1:0] den_reg;
    logic                     ddneg_reg;

    logic signed [SQ-1:0] dd_mag;
    logic [DN-1:0]        mag_x, mag_y;
    cec_pkg::div_work_t   work_next;
    cec_pkg::side_t       side_next;

    always_comb
    begin
        diff_next.ax = DIFF'(in_payload.second_x) - DIFF'(in_payload.first_x);
        diff_next.ay = DIFF'(in_payload.second_y) - DIFF'(in_payload.first_y);
        diff_next.bx = DIFF'(in_payload.third_x) - DIFF'(in_payload.first_x);
        diff_next.by = DIFF'(in_payload.third_y) - DIFF'(in_payload.first_y);
    end

    assign dd_mag = dd4_reg[SQ-1] ? -dd4_reg : dd4_reg;
    assign mag_x  = dxn_reg[DN-1] ? -dxn_reg : dxn_reg;
    assign mag_y  = dyn_reg[DN-1] ? -dyn_reg : dyn_reg;

    always_comb
    begin
        work_next.x.nq  = cec_pkg::QN_BITS'(mag_x) << cec_pkg::FRAC_BITS;
        work_next.x.rem = '0;
        work_next.y.nq  = cec_pkg::QN_BITS'(mag_y) << cec_pkg::FRAC_BITS;
        work_next.y.rem = '0;
        work_next.den   = den_reg;
        side_next.sites     = site_reg[4];
        side_next.collinear = col5_reg;
        side_next.neg_x     = dxn_reg[DN-1] ^ ddneg_reg;
        side_next.neg_y     = dyn_reg[DN-1] ^ ddneg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            site_reg[0] <= in_payload;
            for (int k = 1; k < STAGES - 1; k++)
                site_reg[k] <= site_reg[k-1];
            diff_reg[0] <= diff_next;
            diff_reg[1] <= diff_reg[0];
            diff_reg[2] <= diff_reg[1];
            // lifted-row squares and the DD cross products
            sq_ax_reg <= diff_reg[0].ax * diff_reg[0].ax;
            sq_ay_reg <= diff_reg[0].ay * diff_reg[0].ay;
            sq_bx_reg <= diff_reg[0].bx * diff_reg[0].bx;
            sq_by_reg <= diff_reg[0].by * diff_reg[0].by;
            aby_reg   <= diff_reg[0].ax * diff_reg[0].by;
            bxay_reg  <= diff_reg[0].bx * diff_reg[0].ay;
            sa_reg    <= SQ'(sq_ax_reg) + SQ'(sq_ay_reg);
            sb_reg    <= SQ'(sq_bx_reg) + SQ'(sq_by_reg);
            dd3_reg   <= SQ'(aby_reg) - SQ'(bxay_reg);
            m1_reg    <= sa_reg * diff_reg[2].by;
            m2_reg    <= sb_reg * diff_reg[2].ay;
            m3_reg    <= diff_reg[2].ax * sb_reg;
            m4_reg    <= diff_reg[2].bx * sa_reg;
            dd4_reg   <= dd3_reg;
            col4_reg  <= (dd3_reg == '0);
            dxn_reg   <= DN'(m1_reg) - DN'(m2_reg);
            dyn_reg   <= DN'(m3_reg) - DN'(m4_reg);
            den_reg   <= cec_pkg::DEN_BITS'($unsigned(dd_mag)) << 1;
            ddneg_reg <= dd4_reg[SQ-1];
            col5_reg  <= col4_reg;
            out_work  <= work_next;
            out_side  <= side_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];

endmodule

// ===== hw/rtl/cec_div.sv =====
module cec_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cec_pkg::div_work_t in_work,
    input  cec_pkg::side_t     in_side,
    output logic               out_valid,
    output cec_pkg::div_work_t out_work,
    output cec_pkg::side_t     out_side
);
    localparam int STAGES = cec_pkg::QN_BITS;

    logic [STAGES-1:0]  valid_reg;
    cec_pkg::div_work_t work_reg [STAGES];
    cec_pkg::side_t     side_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    // one quotient bit per stage, both numerators share the divisor
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        cec_pkg::div_work_t prev_work;
        cec_pkg::side_t     prev_side;

        if (g == 0)
        begin : g_first
            assign prev_work = in_work;
            assign prev_side = in_side;
        end
        else
        begin : g_rest
            assign prev_work = work_reg[g-1];
            assign prev_side = side_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[g].x   <= cec_pkg::div_step(prev_work.x, prev_work.den);
                work_reg[g].y   <= cec_pkg::div_step(prev_work.y, prev_work.den);
                work_reg[g].den <= prev_work.den;
                side_reg[g]     <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_work  = work_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== hw/rtl/cec_sqrt.sv =====
module cec_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [cec_pkg::NUM_SITES-1:0][cec_pkg::SS_BITS-1:0] in_rad,
    input  cec_pkg::sq_side_t in_side,
    output logic             out_valid,
    output logic [cec_pkg::NUM_SITES-1:0][cec_pkg::ROOT_BITS-1:0] out_root,
    output cec_pkg::sq_side_t out_side
);
    localparam int STAGES = cec_pkg::ROOT_BITS;
    localparam int LANES  = cec_pkg::NUM_SITES;

    typedef cec_pkg::sqrt_lane_t [LANES-1:0] lanes_t;

    logic [STAGES-1:0] valid_reg;
    lanes_t            work_reg [STAGES];
    cec_pkg::sq_side_t side_reg [STAGES];
    lanes_t            first_work;

    for (genvar j = 0; j < LANES; j++)
    begin : g_init
        assign first_work[j].rad  = in_rad[j];
        assign first_work[j].rem  = '0;
        assign first_work[j].root = '0;
        assign out_root[j]        = work_reg[STAGES-1][j].root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    // one root bit per stage for each of the three distances
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        lanes_t            prev_work;
        cec_pkg::sq_side_t prev_side;

        if (g == 0)
        begin : g_first
            assign prev_work = first_work;
            assign prev_side = in_side;
        end
        else
        begin : g_rest
            assign prev_work = work_reg[g-1];
            assign prev_side = side_reg[g-1];
        end

        for (genvar j = 0; j < LANES; j++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                    work_reg[g][j] <= cec_pkg::sqrt_step(prev_work[j]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[g] <= prev_side;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== hw/rtl/circle_event_circumcenter_top.sv =====
// Circumcenter and circle-event position of three sites.
//
// sites  (sink):   valid/ready/payload carrying the six signed site coordinates.
// circle (source): valid/ready/payload carrying center_x, center_y, event_pos
//                  (signed Q24.8) and status (ok, collinear, saturated).
// A transaction is taken on a rising edge with valid and ready both high.
//
// Throughput: one transaction per cycle while circle.ready does not stall
// the pipeline. Stages at the default widths: 6 determinant + QN_BITS (61)
// divider, one quotient bit each + 6 rounding/distance + ROOT_BITS (33)
// square root, one root bit each + 2 for the maximum radius and the output
// register. The divider and the square root set the depth.
//
// Reset clears every valid bit, so the pipeline comes up empty and no stale
// result appears. When a result sits in the output register and circle.ready
// is low, the whole pipeline holds and sites.ready drops until the result
// is taken; nothing is dropped or repeated.
module circle_event_circumcenter_top (
    input  logic        clk,
    input  logic        rst_n,
    cec_stream_if.sink   sites,
    cec_stream_if.source circle
);
    localparam int NS   = cec_pkg::NUM_SITES;
    localparam int OB   = cec_pkg::OUT_BITS;
    localparam int VB   = cec_pkg::V_BITS;
    localparam int DXB  = cec_pkg::DX_BITS;
    localparam int RB   = cec_pkg::ROOT_BITS;
    localparam int EVB  = cec_pkg::EV_BITS;
    localparam int POST = 6;

    localparam logic signed [EVB-1:0] EV_MAX = EVB'(cec_pkg::OUT_MAX);

    logic en;

    logic               front_valid;
    cec_pkg::div_work_t front_work;
    cec_pkg::side_t     front_side;
    logic               div_valid;
    cec_pkg::div_work_t div_work;
    cec_pkg::side_t     div_side;

    logic [POST-1:0]    post_valid_reg;

    // stage P1: rounding
    logic                       inc_x, inc_y;
    logic [cec_pkg::QC_BITS-1:0] p1_qx_reg, p1_qy_reg;
    cec_pkg::side_t             p1_side_reg;
    // stage P2: range check and sign
    logic signed [VB-1:0]       mx_x, mx_y;
    logic signed [VB-1:0]       p2_offx_reg, p2_offy_reg;
    logic                       p2_overx_reg, p2_overy_reg;
    cec_pkg::side_t             p2_side_reg;
    // stage P3: center assembly and clamp
    logic signed [VB-1:0]       base_x, base_y;
    cec_pkg::clamp_t            clx, cly;
    cec_pkg::sq_side_t          p3_sq_reg;
    cec_pkg::site_in_t          p3_site_reg;
    // stage P4..P6: distances
    logic signed [cec_pkg::COORD_BITS-1:0] site_xs [NS];
    logic signed [cec_pkg::COORD_BITS-1:0] site_ys [NS];
    logic signed [DXB-1:0]      p4_dx_reg [NS];
    logic signed [DXB-1:0]      p4_dy_reg [NS];
    cec_pkg::sq_side_t          p4_sq_reg;
    logic signed [2*DXB-1:0]    p5_sqx_reg [NS];
    logic signed [2*DXB-1:0]    p5_sqy_reg [NS];
    cec_pkg::sq_side_t          p5_sq_reg;
    logic [NS-1:0][cec_pkg::SS_BITS-1:0] p6_rad_reg;
    cec_pkg::sq_side_t          p6_sq_reg;

    logic                       sq_valid;
    logic [NS-1:0][RB-1:0]      sq_root;
    cec_pkg::sq_side_t          sq_side;

    // stage E1: largest radius
    logic [RB-1:0]              max01, rmax;
    logic                       e1_valid_reg;
    logic [RB-1:0]              e1_rmax_reg;
    cec_pkg::sq_side_t          e1_sq_reg;

    // output register
    logic signed [EVB-1:0]      ev_sum;
    cec_pkg::circle_out_t       out_next;
    cec_pkg::circle_out_t       out_reg;
    logic                       out_valid_reg;

    assign en          = !out_valid_reg || circle.ready;
    assign sites.ready = en;

    cec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sites.valid),
        .in_payload (sites.payload),
        .out_valid  (front_valid),
        .out_work   (front_work),
        .out_side   (front_side)
    );

    cec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_work   (front_work),
        .in_side   (front_side),
        .out_valid (div_valid),
        .out_work  (div_work),
        .out_side  (div_side)
    );

    // round half away from zero on the magnitude
    assign inc_x = {div_work.x.rem, 1'b0} >= {1'b0, div_work.den};
    assign inc_y = {div_work.y.rem, 1'b0} >= {1'b0, div_work.den};

    assign mx_x = VB'(p1_qx_reg);
    assign mx_y = VB'(p1_qy_reg);

    assign base_x = VB'(p2_side_reg.sites.first_x) <<< cec_pkg::FRAC_BITS;
    assign base_y = VB'(p2_side_reg.sites.first_y) <<< cec_pkg::FRAC_BITS;
    assign clx = cec_pkg::clamp_center(base_x + p2_offx_reg, p2_overx_reg,
                                       p2_side_reg.neg_x);
    assign cly = cec_pkg::clamp_center(base_y + p2_offy_reg, p2_overy_reg,
                                       p2_side_reg.neg_y);

    assign site_xs[0] = p3_site_reg.first_x;
    assign site_xs[1] = p3_site_reg.second_x;
    assign site_xs[2] = p3_site_reg.third_x;
    assign site_ys[0] = p3_site_reg.first_y;
    assign site_ys[1] = p3_site_reg.second_y;
    assign site_ys[2] = p3_site_reg.third_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_valid_reg <= '0;
        else if (en)
            post_valid_reg <= {post_valid_reg[POST-2:0], div_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_qx_reg   <= cec_pkg::QC_BITS'(div_work.x.nq) + cec_pkg::QC_BITS'(inc_x);
            p1_qy_reg   <= cec_pkg::QC_BITS'(div_work.y.nq) + cec_pkg::QC_BITS'(inc_y);
            p1_side_reg <= div_side;

            p2_overx_reg <= p1_qx_reg > cec_pkg::CENTER_LIMIT;
            p2_overy_reg <= p1_qy_reg > cec_pkg::CENTER_LIMIT;
            p2_offx_reg  <= p1_side_reg.neg_x ? -mx_x : mx_x;
            p2_offy_reg  <= p1_side_reg.neg_y ? -mx_y : mx_y;
            p2_side_reg  <= p1_side_reg;

            p3_sq_reg.cx        <= clx.val;
            p3_sq_reg.cy        <= cly.val;
            p3_sq_reg.sat       <= clx.sat || cly.sat;
            p3_sq_reg.collinear <= p2_side_reg.collinear;
            p3_site_reg         <= p2_side_reg.sites;

            p4_sq_reg <= p3_sq_reg;
            p5_sq_reg <= p4_sq_reg;
            p6_sq_reg <= p5_sq_reg;
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_dist
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p4_dx_reg[j]  <= (DXB'(site_xs[j]) <<< cec_pkg::FRAC_BITS) - DXB'(p3_sq_reg.cx);
                p4_dy_reg[j]  <= (DXB'(site_ys[j]) <<< cec_pkg::FRAC_BITS) - DXB'(p3_sq_reg.cy);
                p5_sqx_reg[j] <= p4_dx_reg[j] * p4_dx_reg[j];
                p5_sqy_reg[j] <= p4_dy_reg[j] * p4_dy_reg[j];
                p6_rad_reg[j] <= cec_pkg::SS_BITS'($unsigned(p5_sqx_reg[j]))
                               + cec_pkg::SS_BITS'($unsigned(p5_sqy_reg[j]));
            end
        end
    end

    cec_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (post_valid_reg[POST-1]),
        .in_rad    (p6_rad_reg),
        .in_side   (p6_sq_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign max01 = (sq_root[1] > sq_root[0]) ? sq_root[1] : sq_root[0];
    assign rmax  = (sq_root[2] > max01) ? sq_root[2] : max01;

    assign ev_sum = EVB'(e1_sq_reg.cx) + EVB'(e1_rmax_reg);

    always_comb
    begin
        out_next.center_x  = e1_sq_reg.cx;
        out_next.center_y  = e1_sq_reg.cy;
        out_next.event_pos = ev_sum[OB-1:0];
        out_next.status    = cec_pkg::STATUS_OK;
        if (e1_sq_reg.collinear)
        begin
            out_next.center_x  = '0;
            out_next.center_y  = '0;
            out_next.event_pos = '0;
            out_next.status    = cec_pkg::STATUS_COLLINEAR;
        end
        else if (e1_sq_reg.sat || ev_sum > EV_MAX)
        begin
            // both a clamped center and an event overflow pin event_pos high
            out_next.event_pos = cec_pkg::OUT_MAX;
            out_next.status    = cec_pkg::STATUS_SATURATED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg  <= sq_valid;
            out_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_rmax_reg <= rmax;
            e1_sq_reg   <= sq_side;
            out_reg     <= out_next;
        end
    end

    assign circle.valid   = out_valid_reg;
    assign circle.payload = out_reg;

endmodule

// ===== hw/rtl/cec_checker.sv =====
module cec_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [cec_pkg::OUT_BITS-1:0] center_x,
    input logic signed [cec_pkg::OUT_BITS-1:0] center_y,
    input logic signed [cec_pkg::OUT_BITS-1:0] event_pos,
    input logic [1:0]                         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(center_x) && $stable(center_y)
                                    && $stable(event_pos) && $stable(status))
        else $error("result changed while stalled");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

    a_collinear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cec_pkg::STATUS_COLLINEAR
            |-> center_x == '0 && center_y == '0 && event_pos == '0)
        else $error("collinear result carries nonzero fields");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cec_pkg::STATUS_SATURATED |-> event_pos == cec_pkg::OUT_MAX)
        else $error("saturated result without pinned event position");

    a_event_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cec_pkg::STATUS_OK |-> event_pos >= center_x)
        else $error("event position left of center");

endmodule

bind circle_event_circumcenter_top cec_checker u_cec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sites.ready),
    .out_valid (circle.valid),
    .out_ready (circle.ready),
    .center_x  (circle.payload.center_x),
    .center_y  (circle.payload.center_y),
    .event_pos (circle.payload.event_pos),
    .status    (circle.payload.status)
);
